/* src/bcc_pkg.sv */
// bcc_pkg: shared types, widths and register codes of the balance cascade controller
// no dependencies
package bcc_pkg;

   localparam int GAIN_W   = 26;
   localparam int WDATA_W  = 26;
   localparam int CSR_IDX_W = 3;
   localparam int ACC_W    = 72;
   localparam int DVD_W    = 44;
   localparam int FS_W     = 40;
   localparam int SI_W     = 40;
   localparam int DUTY_W   = 13;

   localparam int OUTPUT_LIMIT_DEF   = 7000;
   localparam int INTEGRAL_LIMIT_DEF = 3000;
   localparam int TILT_LIMIT_DEF     = 50;

   localparam logic [CSR_IDX_W-1:0] REG_UPRIGHT_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UPRIGHT_KD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KI   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MID_ANGLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_ENABLE = 3'd5;

   localparam logic [GAIN_W-1:0] UPRIGHT_KP_RST = 26'd19660800;
   localparam logic [GAIN_W-1:0] UPRIGHT_KD_RST = 26'd90440;
   localparam logic [GAIN_W-1:0] SPEED_KP_RST   = 26'd353894;
   localparam logic [GAIN_W-1:0] SPEED_KI_RST   = 26'd1769;

   localparam logic [6:0] DEN_FILTER  = 7'd10;
   localparam logic [6:0] DEN_UPRIGHT = 7'd100;

   // which product the serial multiplier is working on
   localparam logic [1:0] PH_FS_KP   = 2'd0;
   localparam logic [1:0] PH_SI_KI   = 2'd1;
   localparam logic [1:0] PH_ANG_KP  = 2'd2;
   localparam logic [1:0] PH_GYRO_KD = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_FILT,
      ST_INTEG,
      ST_MUL,
      ST_SPEED,
      ST_UP_LOAD,
      ST_DIV_UP,
      ST_FINISH
   } state_type;

endpackage

/* src/balance_robot_cascade_controller_core.sv */
// balance_robot_cascade_controller_core: upright pd plus speed pi cascade for a two-wheel robot
// depends on bcc_pkg (widths, register codes, state type)
//
// channel | ports                     | dir | moves
// req     | req_valid / req_ready     | in  | one sensor item per control tick
// rsp     | rsp_valid / rsp_ready     | out | one motor command item per sensor item
// csr     | csr_we, csr_index, wdata  | in  | gain, balance angle and enable writes
//
// a result is formed in order by a 44-step restoring divide for the speed filter, the
// integral update, four 26-step shift-add products on one shared multiplier, the speed and
// upright load states, a second 44-step divide for the upright scaling, the finish state
// that forms the commands, and the idle state that accepts the next item
// reset is synchronous and clears control state, loop state and configuration registers to defaults
// a finished item waits in the output register; a new item can start meanwhile and
// stalls in its last step until the old item is taken
module balance_robot_cascade_controller_core #(
   parameter int OUTPUT_LIMIT   = bcc_pkg::OUTPUT_LIMIT_DEF,
   parameter int INTEGRAL_LIMIT = bcc_pkg::INTEGRAL_LIMIT_DEF,
   parameter int TILT_LIMIT_DEG = bcc_pkg::TILT_LIMIT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_roll_angle,
   input  logic signed [15:0]             req_gyro_rate,
   input  logic signed [15:0]             req_left_count,
   input  logic signed [15:0]             req_right_count,
   input  logic                           req_go_forward,
   input  logic                           req_go_reverse,
   input  logic signed [9:0]              req_turn_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bcc_pkg::DUTY_W-1:0]     rsp_duty_a,
   output logic [bcc_pkg::DUTY_W-1:0]     rsp_duty_b,
   output logic                           rsp_a_in1,
   output logic                           rsp_a_in2,
   output logic                           rsp_b_in1,
   output logic                           rsp_b_in2,
   output logic                           rsp_fallen,
   input  logic                           csr_we,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcc_pkg::WDATA_W-1:0]    csr_wdata
);

   localparam int ACC_W  = bcc_pkg::ACC_W;
   localparam int DVD_W  = bcc_pkg::DVD_W;
   localparam int GAIN_W = bcc_pkg::GAIN_W;
   // integral bound in q16, and the roll values that mean a tilt
   localparam logic signed [41:0] ILIM = 42'(longint'(INTEGRAL_LIMIT) * 65536);
   localparam int TILT_HI = (TILT_LIMIT_DEG + 1) * 100;
   localparam logic signed [45:0] OLIM = 46'(OUTPUT_LIMIT);

   // configuration registers
   logic [GAIN_W-1:0] ukp_ff, ukd_ff, skp_ff, ski_ff;
   logic signed [15:0] mid_ff;
   logic run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ukp_ff <= bcc_pkg::UPRIGHT_KP_RST;
         ukd_ff <= bcc_pkg::UPRIGHT_KD_RST;
         skp_ff <= bcc_pkg::SPEED_KP_RST;
         ski_ff <= bcc_pkg::SPEED_KI_RST;
         mid_ff <= '0;
         run_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            bcc_pkg::REG_UPRIGHT_KP: ukp_ff <= csr_wdata;
            bcc_pkg::REG_UPRIGHT_KD: ukd_ff <= csr_wdata;
            bcc_pkg::REG_SPEED_KP:   skp_ff <= csr_wdata;
            bcc_pkg::REG_SPEED_KI:   ski_ff <= csr_wdata;
            bcc_pkg::REG_MID_ANGLE:  mid_ff <= csr_wdata[15:0];
            bcc_pkg::REG_RUN_ENABLE: run_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   bcc_pkg::state_type state_ff, state_in;

   // loop state
   logic signed [bcc_pkg::FS_W-1:0] fs_ff;
   logic signed [bcc_pkg::SI_W-1:0] si_ff;
   logic tilt_ff;
   logic [bcc_pkg::DUTY_W-1:0] hda_ff, hdb_ff;
   logic [3:0] dirs_ff;

   // latched item
   logic signed [15:0] roll_ff, gyro_ff;
   logic signed [9:0] turn_ff;
   logic fwd_ff, rev_ff;

   // shared serial divider and multiplier
   logic [DVD_W-1:0] dvd_ff;
   logic [6:0] rem_ff, den_ff;
   logic neg_ff;
   logic [5:0] cnt_ff;
   logic signed [ACC_W-1:0] acc_ff, mcd_ff;
   logic [GAIN_W-1:0] mpl_ff;
   logic [1:0] ph_ff;
   logic signed [40:0] spd_ff;
   logic signed [44:0] up_ff;

   logic rsp_valid_ff;
   logic [bcc_pkg::DUTY_W-1:0] oda_ff, odb_ff;
   logic [3:0] odirs_ff;
   logic ofall_ff;

   // filter numerator at accept: 3*(l+r)*65536 + 7*fs + 5
   logic signed [DVD_W-1:0] filt_num;
   logic signed [16:0] enc_sum;
   always_comb begin
      enc_sum  = 17'(req_left_count) + 17'(req_right_count);
      filt_num = (DVD_W'(enc_sum) * 44'sd3 <<< 16) + (DVD_W'(fs_ff) <<< 3)
                 - DVD_W'(fs_ff) + 44'sd5;
   end

   // one restoring division step
   logic [7:0] rem_sh;
   logic div_ge;
   logic [6:0] rem_step;
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      div_ge   = rem_sh >= {1'b0, den_ff};
      rem_step = div_ge ? 7'(rem_sh - {1'b0, den_ff}) : rem_sh[6:0];
   end
   logic last_step;
   assign last_step = (cnt_ff == 6'(DVD_W - 1));
   logic mul_last;
   assign mul_last = (cnt_ff == 6'(GAIN_W - 1));

   // filter result once the divide completes, floor for negative numerators
   logic [DVD_W-1:0] q_fin;
   logic [6:0] r_fin;
   logic signed [bcc_pkg::FS_W-1:0] fs_new;
   always_comb begin
      q_fin  = {dvd_ff[DVD_W-2:0], div_ge};
      r_fin  = rem_step;
      fs_new = neg_ff ? -(bcc_pkg::FS_W'(q_fin) + bcc_pkg::FS_W'(r_fin != 7'd0))
                      : bcc_pkg::FS_W'(q_fin);
   end

   // integral update with clamp and clear
   logic signed [41:0] tgt, isum, iclamp;
   always_comb begin
      tgt = fwd_ff ? -42'sd131072000 : (rev_ff ? 42'sd131072000 : 42'sd0);
      isum = 42'(si_ff) + 42'(fs_ff) - tgt;
      if (isum > ILIM) iclamp = ILIM;
      else if (isum < -ILIM) iclamp = -ILIM;
      else iclamp = isum;
   end

   // magnitude of the product sum
   logic signed [ACC_W-1:0] acc_mag;
   assign acc_mag = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;

   // command forming
   logic signed [45:0] csum, left_c, right_c, left_l, right_l;
   logic signed [45:0] left_abs, right_abs;
   logic tilt_now;
   always_comb begin
      csum    = 46'(spd_ff) + 46'(up_ff);
      left_c  = csum + 46'(turn_ff);
      right_c = csum - 46'(turn_ff);
      left_l  = (left_c > OLIM) ? OLIM : ((left_c < -OLIM) ? -OLIM : left_c);
      right_l = (right_c > OLIM) ? OLIM : ((right_c < -OLIM) ? -OLIM : right_c);
      left_abs  = left_l[45] ? -left_l : left_l;
      right_abs = right_l[45] ? -right_l : right_l;
      tilt_now  = (int'(roll_ff) >= TILT_HI) || (int'(roll_ff) <= -TILT_HI);
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcc_pkg::ST_IDLE:     if (req_valid) state_in = bcc_pkg::ST_DIV_FILT;
         bcc_pkg::ST_DIV_FILT: if (last_step) state_in = bcc_pkg::ST_INTEG;
         bcc_pkg::ST_INTEG:    state_in = bcc_pkg::ST_MUL;
         bcc_pkg::ST_MUL: begin
            if (mul_last && ph_ff == bcc_pkg::PH_SI_KI) state_in = bcc_pkg::ST_SPEED;
            else if (mul_last && ph_ff == bcc_pkg::PH_GYRO_KD)
               state_in = bcc_pkg::ST_UP_LOAD;
         end
         bcc_pkg::ST_SPEED:    state_in = bcc_pkg::ST_MUL;
         bcc_pkg::ST_UP_LOAD:  state_in = bcc_pkg::ST_DIV_UP;
         bcc_pkg::ST_DIV_UP:   if (last_step) state_in = bcc_pkg::ST_FINISH;
         bcc_pkg::ST_FINISH:   if (out_free) state_in = bcc_pkg::ST_IDLE;
         default:              state_in = bcc_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = (state_ff == bcc_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bcc_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // loop state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= '0;
         si_ff <= '0;
         tilt_ff <= 1'b0;
         hda_ff <= '0;
         hdb_ff <= '0;
         dirs_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == bcc_pkg::ST_DIV_FILT && last_step) fs_ff <= fs_new;
         if (state_ff == bcc_pkg::ST_INTEG)
            si_ff <= (tilt_ff || !run_ff) ? '0 : bcc_pkg::SI_W'(iclamp);
         if (state_ff == bcc_pkg::ST_FINISH && out_free) begin
            tilt_ff <= tilt_now;
            rsp_valid_ff <= 1'b1;
            if (run_ff && !tilt_now) begin
               hda_ff  <= left_abs[bcc_pkg::DUTY_W-1:0];
               hdb_ff  <= right_abs[bcc_pkg::DUTY_W-1:0];
               dirs_ff <= {right_l > 0, !(right_l > 0), !(left_l > 0), left_l > 0};
            end else if (run_ff) begin
               hda_ff <= '0;
               hdb_ff <= '0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the result, loaded with the same values the held state takes
   always_ff @(posedge clock) begin
      if (state_ff == bcc_pkg::ST_FINISH && out_free) begin
         ofall_ff <= tilt_now;
         if (run_ff && !tilt_now) begin
            oda_ff   <= left_abs[bcc_pkg::DUTY_W-1:0];
            odb_ff   <= right_abs[bcc_pkg::DUTY_W-1:0];
            odirs_ff <= {right_l > 0, !(right_l > 0), !(left_l > 0), left_l > 0};
         end else if (run_ff) begin
            oda_ff   <= '0;
            odb_ff   <= '0;
            odirs_ff <= dirs_ff;
         end else begin
            oda_ff   <= hda_ff;
            odb_ff   <= hdb_ff;
            odirs_ff <= dirs_ff;
         end
      end
   end

   // datapath: latches, serial divider, serial multiplier
   always_ff @(posedge clock) begin
      case (state_ff)
         bcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               roll_ff <= req_roll_angle;
               gyro_ff <= req_gyro_rate;
               turn_ff <= req_turn_offset;
               fwd_ff  <= req_go_forward;
               rev_ff  <= req_go_reverse;
               neg_ff  <= filt_num[DVD_W-1];
               dvd_ff  <= filt_num[DVD_W-1] ? DVD_W'(-filt_num) : DVD_W'(filt_num);
               rem_ff  <= '0;
               den_ff  <= bcc_pkg::DEN_FILTER;
               cnt_ff  <= '0;
            end
         end
         bcc_pkg::ST_DIV_FILT, bcc_pkg::ST_DIV_UP: begin
            dvd_ff <= {dvd_ff[DVD_W-2:0], div_ge};
            rem_ff <= rem_step;
            cnt_ff <= cnt_ff + 6'd1;
            if (state_ff == bcc_pkg::ST_DIV_UP && last_step)
               up_ff <= neg_ff ? -45'(q_fin) : 45'(q_fin);
         end
         bcc_pkg::ST_INTEG: begin
            acc_ff <= '0;
            mcd_ff <= ACC_W'(fs_ff);
            mpl_ff <= skp_ff;
            ph_ff  <= bcc_pkg::PH_FS_KP;
            cnt_ff <= '0;
         end
         bcc_pkg::ST_MUL: begin
            acc_ff <= acc_ff + (mpl_ff[0] ? mcd_ff : '0);
            cnt_ff <= mul_last ? 6'd0 : cnt_ff + 6'd1;
            if (mul_last && ph_ff == bcc_pkg::PH_FS_KP) begin
               mcd_ff <= ACC_W'(si_ff);
               mpl_ff <= ski_ff;
               ph_ff  <= bcc_pkg::PH_SI_KI;
            end else if (mul_last && ph_ff == bcc_pkg::PH_ANG_KP) begin
               mcd_ff <= ACC_W'(gyro_ff) * 72'sd100;
               mpl_ff <= ukd_ff;
               ph_ff  <= bcc_pkg::PH_GYRO_KD;
            end else begin
               mcd_ff <= mcd_ff <<< 1;
               mpl_ff <= mpl_ff >> 1;
            end
         end
         bcc_pkg::ST_SPEED: begin
            spd_ff <= acc_ff[ACC_W-1] ? -41'(acc_mag[ACC_W-1:32]) : 41'(acc_mag[ACC_W-1:32]);
            acc_ff <= '0;
            mcd_ff <= ACC_W'(17'(roll_ff) - 17'(mid_ff));
            mpl_ff <= ukp_ff;
            ph_ff  <= bcc_pkg::PH_ANG_KP;
            cnt_ff <= '0;
         end
         bcc_pkg::ST_UP_LOAD: begin
            // truncate toward zero: drop 16 bits of the magnitude, then divide by 100
            neg_ff <= acc_ff[ACC_W-1];
            dvd_ff <= acc_mag[DVD_W+15:16];
            rem_ff <= '0;
            den_ff <= bcc_pkg::DEN_UPRIGHT;
            cnt_ff <= '0;
         end
         default: ;
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty_a = oda_ff;
   assign rsp_duty_b = odb_ff;
   assign rsp_a_in1  = odirs_ff[0];
   assign rsp_a_in2  = odirs_ff[1];
   assign rsp_b_in1  = odirs_ff[2];
   assign rsp_b_in2  = odirs_ff[3];
   assign rsp_fallen = ofall_ff;

`ifndef SYNTH
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == bcc_pkg::ST_DIV_FILT)
      else $error("accepted item did not start the filter divide");
   a_dirs: assert property (@(posedge clock) disable iff (reset)
      $onehot0(dirs_ff[1:0]) && $onehot0(dirs_ff[3:2]))
      else $error("bridge direction bits both high");
   a_fallen_duty: assert property (@(posedge clock) disable iff (reset)
      state_ff == bcc_pkg::ST_FINISH && out_free && run_ff && tilt_now
      |=> hda_ff == '0 && hdb_ff == '0)
      else $error("duty not zeroed on tilt");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != bcc_pkg::ST_IDLE |-> !req_ready)
      else $error("item taken while busy");
`endif

endmodule
